### hdl/cfc_pkg.sv
package cfc_pkg;

   // Field widths of the fraction and its convergents.
   localparam int ValueWidth = 32;
   localparam int DenWidth   = ValueWidth - 1;
   localparam int ExtWidth   = ValueWidth + 1;
   localparam int IdxWidth   = 6;
   localparam int MaxTerms   = 46;
   localparam int CntWidth   = $clog2(ValueWidth + 1);
   localparam int QueueDepth = 2;
   localparam int QPtrWidth  = 1;
   localparam int QCntWidth  = 2;

   // One classified fraction: numerator split into sign and magnitude.
   typedef struct packed {
      logic [ValueWidth-1:0] num_mag;
      logic                  num_neg;
      logic [DenWidth-1:0]   den;
   } cfc_job_type;

   // Sequencer states of the expansion engine.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_DIV,
      ST_MUL_P,
      ST_MUL_Q,
      ST_COMMIT,
      ST_OUT
   } cfc_state_type;

endpackage

### hdl/continued_fraction_convergents.sv
// Channel | Direction | Handshake             | Payload
// req     | in        | req_valid / req_ready | frac_num, frac_den
// rsp     | out       | rsp_valid / rsp_ready | partial_quotient, conv_num, conv_den,
//         |           |                       | term_index, last_term
// Each term passes through a start state, the bit-serial divider, the shared
// multiply-add (numerator, then denominator), a commit state and a result state.
// The result state holds, and so stalls the engine, while rsp_ready is low.
// A two-entry queue lets the front take new transactions while the engine works.
// Reset is synchronous and active high; no clearing pass is needed.
module continued_fraction_convergents (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [cfc_pkg::ValueWidth-1:0] req_frac_num,
   input  logic [cfc_pkg::DenWidth-1:0]   req_frac_den,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [cfc_pkg::ValueWidth-1:0] rsp_partial_quotient,
   output logic [cfc_pkg::ValueWidth-1:0] rsp_conv_num,
   output logic [cfc_pkg::DenWidth-1:0]   rsp_conv_den,
   output logic [cfc_pkg::IdxWidth-1:0]   rsp_term_index,
   output logic                           rsp_last_term
);
   import cfc_pkg::*;

   logic        q_full, q_push, q_pop, q_valid;
   cfc_job_type push_job, pop_job;

   // Classification of incoming fractions.
   cfc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_frac_num (req_frac_num),
      .req_frac_den (req_frac_den),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_job        (push_job)
   );

   // Decoupling queue.
   cfc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (push_job),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .pop_job   (pop_job)
   );

   // Expansion engine.
   cfc_back u_back (
      .clock                (clock),
      .reset                (reset),
      .q_valid              (q_valid),
      .q_job                (pop_job),
      .q_pop                (q_pop),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_partial_quotient (rsp_partial_quotient),
      .rsp_conv_num         (rsp_conv_num),
      .rsp_conv_den         (rsp_conv_den),
      .rsp_term_index       (rsp_term_index),
      .rsp_last_term        (rsp_last_term)
   );

endmodule

### hdl/cfc_front.sv
module cfc_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [cfc_pkg::ValueWidth-1:0] req_frac_num,
   input  logic [cfc_pkg::DenWidth-1:0]   req_frac_den,
   input  logic                           q_full,
   output logic                           q_push,
   output cfc_pkg::cfc_job_type           q_job
);
   import cfc_pkg::*;

   logic accept;

   // The front takes a transaction whenever the queue has room.
   assign req_ready = ~q_full;
   assign accept    = req_valid & req_ready;

   // A zero denominator yields no terms, so that transaction is dropped here.
   assign q_push = accept & (req_frac_den != '0);

   // Split the numerator into sign and magnitude for the divider.
   always_comb begin
      q_job.num_neg = req_frac_num[ValueWidth-1];
      q_job.num_mag = req_frac_num[ValueWidth-1] ? (~req_frac_num + 1'b1) : req_frac_num;
      q_job.den     = req_frac_den;
   end

   // Dropped transactions never reach the queue.
   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      (accept && req_frac_den == '0) |-> !q_push)
      else $error("zero denominator pushed");

endmodule

### hdl/cfc_queue.sv
module cfc_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  cfc_pkg::cfc_job_type push_job,
   output logic                 full,
   input  logic                 pop,
   output logic                 not_empty,
   output cfc_pkg::cfc_job_type pop_job
);
   import cfc_pkg::*;

   cfc_job_type                 slot_ff [QueueDepth];
   logic [QPtrWidth-1:0]        wr_ff, wr_in, rd_ff, rd_in;
   logic [QCntWidth-1:0]        cnt_ff, cnt_in;

   assign full      = (cnt_ff == QCntWidth'(QueueDepth));
   assign not_empty = (cnt_ff != '0);
   assign pop_job   = slot_ff[rd_ff];

   // Pointer and count updates.
   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop  ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + QCntWidth'(push) - QCntWidth'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !not_empty |-> !pop)
      else $error("queue underflow");
   a_count: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCntWidth'(QueueDepth))
      else $error("queue count out of range");

endmodule

### hdl/cfc_div.sv
module cfc_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [cfc_pkg::ValueWidth-1:0] dividend,
   input  logic [cfc_pkg::ValueWidth-1:0] divisor,
   output logic                           done,
   output logic [cfc_pkg::ValueWidth-1:0] quotient,
   output logic [cfc_pkg::ValueWidth-1:0] remainder
);
   import cfc_pkg::*;

   logic [ValueWidth-1:0] acc_ff, acc_in, quo_ff, quo_in, dvs_ff, dvs_in;
   logic [CntWidth-1:0]   cnt_ff, cnt_in;
   logic                  busy_ff, busy_in, done_ff, done_in;
   logic [ValueWidth:0]   shifted, diff;

   // One restoring step: shift in the next dividend bit, subtract if it fits.
   always_comb begin
      shifted = {acc_ff, quo_ff[ValueWidth-1]};
      diff    = shifted - {1'b0, dvs_ff};
      acc_in  = acc_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = CntWidth'(ValueWidth);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[ValueWidth]) begin
            acc_in = diff[ValueWidth-1:0];
            quo_in = {quo_ff[ValueWidth-2:0], 1'b1};
         end else begin
            acc_in = shifted[ValueWidth-1:0];
            quo_in = {quo_ff[ValueWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = acc_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without work");

endmodule

### hdl/cfc_back.sv
module cfc_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_valid,
   input  cfc_pkg::cfc_job_type           q_job,
   output logic                           q_pop,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [cfc_pkg::ValueWidth-1:0] rsp_partial_quotient,
   output logic [cfc_pkg::ValueWidth-1:0] rsp_conv_num,
   output logic [cfc_pkg::DenWidth-1:0]   rsp_conv_den,
   output logic [cfc_pkg::IdxWidth-1:0]   rsp_term_index,
   output logic                           rsp_last_term
);
   import cfc_pkg::*;

   cfc_state_type state_ff, state_in;

   // Remainder pair as sign and magnitude; convergents in wrapping extended width.
   logic [ValueWidth-1:0] rh_mag_ff, rl_mag_ff, rem_ff;
   logic                  rh_neg_ff, rl_neg_ff;
   logic [ExtWidth-1:0]   pp_ff, pq_ff, cp_ff, cq_ff, np_ff, nq_ff, a_ff;
   logic [IdxWidth-1:0]   n_ff;
   logic                  last_ff;

   logic                  div_start, div_done;
   logic [ValueWidth-1:0] div_quo, div_rem;
   logic [ExtWidth-1:0]   quo_ext, mul_x, mul_y, mac, on_val, od_val;
   logic                  first, last_now;

   logic                  rsp_valid_ff;
   logic [ValueWidth-1:0] pq_out_ff, cn_out_ff;
   logic [DenWidth-1:0]   cd_out_ff;
   logic [IdxWidth-1:0]   idx_out_ff;

   cfc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (rh_mag_ff),
      .divisor   (rl_mag_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // Shared multiply-add for both convergent recurrences.
   always_comb begin
      first    = (n_ff == '0);
      quo_ext  = {1'b0, div_quo};
      mul_x    = (state_ff == ST_MUL_P) ? cp_ff : cq_ff;
      mul_y    = (state_ff == ST_MUL_P) ? pp_ff : pq_ff;
      mac      = a_ff * mul_x + mul_y;
      on_val   = nq_ff[ExtWidth-1] ? (~np_ff + 1'b1) : np_ff;
      od_val   = nq_ff[ExtWidth-1] ? (~nq_ff + 1'b1) : nq_ff;
      last_now = (rem_ff == '0) || (n_ff == IdxWidth'(MaxTerms - 1));
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (q_valid) state_in = ST_START;
         ST_START:  state_in = ST_DIV;
         ST_DIV:    if (div_done) state_in = ST_MUL_P;
         ST_MUL_P:  state_in = ST_MUL_Q;
         ST_MUL_Q:  state_in = ST_COMMIT;
         ST_COMMIT: state_in = ST_OUT;
         ST_OUT: begin
            if (rsp_ready) state_in = last_ff ? ST_IDLE : ST_START;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      q_pop     = 1'b0;
      div_start = 1'b0;
      case (state_ff)
         ST_IDLE:  q_pop = q_valid;
         ST_START: div_start = 1'b1;
         default: begin
            q_pop     = 1'b0;
            div_start = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_COMMIT) begin
            rsp_valid_ff <= 1'b1;
         end else if (state_ff == ST_OUT && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            rh_mag_ff <= q_job.num_mag;
            rh_neg_ff <= q_job.num_neg;
            rl_mag_ff <= {1'b0, q_job.den};
            rl_neg_ff <= 1'b0;
            pp_ff     <= ExtWidth'(1);
            pq_ff     <= '0;
            cp_ff     <= '0;
            cq_ff     <= ExtWidth'(1);
            n_ff      <= '0;
         end
         ST_DIV: begin
            if (div_done) begin
               a_ff   <= (rh_neg_ff ^ rl_neg_ff) ? (~quo_ext + 1'b1) : quo_ext;
               rem_ff <= div_rem;
            end
         end
         ST_MUL_P: np_ff <= first ? a_ff : mac;
         ST_MUL_Q: nq_ff <= first ? ExtWidth'(1) : mac;
         ST_COMMIT: begin
            pp_ff      <= cp_ff;
            pq_ff      <= cq_ff;
            cp_ff      <= np_ff;
            cq_ff      <= nq_ff;
            rh_mag_ff  <= rl_mag_ff;
            rh_neg_ff  <= rl_neg_ff;
            rl_mag_ff  <= rem_ff;
            rl_neg_ff  <= rh_neg_ff;
            last_ff    <= last_now;
            pq_out_ff  <= a_ff[ValueWidth-1:0];
            cn_out_ff  <= on_val[ValueWidth-1:0];
            cd_out_ff  <= od_val[DenWidth-1:0];
            idx_out_ff <= n_ff;
         end
         ST_OUT: begin
            if (rsp_ready && !last_ff) n_ff <= n_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_partial_quotient = pq_out_ff;
   assign rsp_conv_num         = cn_out_ff;
   assign rsp_conv_den         = cd_out_ff;
   assign rsp_term_index       = idx_out_ff;
   assign rsp_last_term        = last_ff;

   a_out_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |-> rsp_valid_ff)
      else $error("result state without valid");
   a_valid_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_OUT))
      else $error("valid outside result state");
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (idx_out_ff <= IdxWidth'(MaxTerms - 1)))
      else $error("term index out of range");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (state_ff == ST_START))
      else $error("pop did not start a job");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

   import cfc_pkg::*;

   // One expected convergent, at the widths of the result ports.
   typedef struct {
      logic [ValueWidth-1:0] quot;
      logic [ValueWidth-1:0] cnum;
      logic [DenWidth-1:0]   cden;
      logic [IdxWidth-1:0]   idx;
      logic                  last;
   } convergent_type;

   // One directed fraction; a typed expectation stands for a single-term result.
   typedef struct {
      logic [ValueWidth-1:0] num;
      logic [DenWidth-1:0]   den;
      bit                    typed;
      logic [ValueWidth-1:0] quot;
   } fraction_row_type;

   localparam int NumRandom = 290;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [ValueWidth-1:0] req_frac_num;
   logic [DenWidth-1:0]   req_frac_den;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [ValueWidth-1:0] rsp_partial_quotient;
   logic [ValueWidth-1:0] rsp_conv_num;
   logic [DenWidth-1:0]   rsp_conv_den;
   logic [IdxWidth-1:0]   rsp_term_index;
   logic                  rsp_last_term;

   convergent_type   convergents_due[$];
   fraction_row_type directed_rows[$];
   int               error_count;
   int               fractions_sent;
   int               terms_checked;
   int               deep_fractions;

   continued_fraction_convergents dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_frac_num         (req_frac_num),
      .req_frac_den         (req_frac_den),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_partial_quotient (rsp_partial_quotient),
      .rsp_conv_num         (rsp_conv_num),
      .rsp_conv_den         (rsp_conv_den),
      .rsp_term_index       (rsp_term_index),
      .rsp_last_term        (rsp_last_term)
   );

   // Free-running 10 ns clock.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Prints one mismatch and counts it.
   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   // Appends one convergent to the tail of the expected list.
   function automatic void expect_convergent(input convergent_type c);
      convergents_due.insert(convergents_due.size(), c);
   endfunction

   // Expands num/den into its partial quotients and convergents and queues them.
   function automatic void expand_fraction(input logic [ValueWidth-1:0] num,
                                           input logic [DenWidth-1:0] den);
      longint         rem_hi;
      longint         rem_lo;
      longint         quo;
      longint         rmd;
      longint         p_old;
      longint         q_old;
      longint         p_cur;
      longint         q_cur;
      longint         p_new;
      longint         q_new;
      int             k;
      convergent_type c;
      rem_hi = longint'($signed(num));
      rem_lo = longint'(den);
      p_old  = 1;
      q_old  = 0;
      p_cur  = 0;
      q_cur  = 1;
      k      = 0;
      while (rem_lo != 0 && k < MaxTerms) begin
         quo = rem_hi / rem_lo;
         rmd = rem_hi % rem_lo;
         if (k == 0) begin
            p_new = quo;
            q_new = 1;
         end else begin
            p_new = quo * p_cur + p_old;
            q_new = quo * q_cur + q_old;
         end
         p_old  = p_cur;
         q_old  = q_cur;
         p_cur  = p_new;
         q_cur  = q_new;
         rem_hi = rem_lo;
         rem_lo = rmd;
         // Keep the sign on the numerator.
         if (q_cur < 0) begin
            p_new = -p_cur;
            q_new = -q_cur;
         end
         c.quot = quo[ValueWidth-1:0];
         c.cnum = p_new[ValueWidth-1:0];
         c.cden = q_new[DenWidth-1:0];
         c.idx  = k[IdxWidth-1:0];
         c.last = (rem_lo == 0) || (k == MaxTerms - 1);
         expect_convergent(c);
         k++;
      end
      if (k > 20) deep_fractions++;
   endfunction

   // Drives one fraction and waits for its transaction to complete.
   task automatic send_fraction(input logic [ValueWidth-1:0] num,
                                input logic [DenWidth-1:0] den,
                                input bit typed, input logic [ValueWidth-1:0] quot);
      convergent_type c;
      req_valid    = 1'b1;
      req_frac_num = num;
      req_frac_den = den;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (typed) begin
         c.quot = quot;
         c.cnum = quot;
         c.cden = DenWidth'(1);
         c.idx  = '0;
         c.last = 1'b1;
         expect_convergent(c);
      end else begin
         expand_fraction(num, den);
      end
      fractions_sent++;
      @(negedge clock);
   endtask

   // Ends the sender's burst with a random gap, now and then none.
   task automatic sender_gap(inout int burst_left);
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      burst_left = $urandom_range(0, 7);
      req_valid  = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clock);
   endtask

   function automatic fraction_row_type make_row(input logic [ValueWidth-1:0] num,
                                                 input logic [DenWidth-1:0] den,
                                                 input bit typed = 0,
                                                 input logic [ValueWidth-1:0] quot = 0);
      fraction_row_type r;
      r.num   = num;
      r.den   = den;
      r.typed = typed;
      r.quot  = quot;
      return r;
   endfunction

   // Appends one directed row to the stimulus table.
   function automatic void add_row(input logic [ValueWidth-1:0] num,
                                   input logic [DenWidth-1:0] den,
                                   input bit typed = 0,
                                   input logic [ValueWidth-1:0] quot = 0);
      directed_rows.insert(directed_rows.size(), make_row(num, den, typed, quot));
   endfunction

   // Receiver stall pattern: long ready stretches, light and heavy stalling.
   initial begin
      int mode;
      int span;
      rsp_ready = 1'b0;
      forever begin
         mode = $urandom_range(0, 2);
         span = $urandom_range(10, 120);
         repeat (span) begin
            @(negedge clock);
            case (mode)
               0: begin
                  rsp_ready = 1'b1;
               end
               1: begin
                  rsp_ready = ($urandom_range(0, 3) != 0);
               end
               default: begin
                  rsp_ready = ($urandom_range(0, 4) == 0);
               end
            endcase
         end
      end
   end

   // Compares each accepted result transaction with the oldest expected one.
   always @(posedge clock) begin
      convergent_type c;
      if (!reset && rsp_valid && rsp_ready) begin
         if (convergents_due.size() == 0) begin
            report_mismatch($sformatf("unexpected term q=%0d idx=%0d",
                                      $signed(rsp_partial_quotient), rsp_term_index));
         end else begin
            c = convergents_due.pop_front();
            terms_checked++;
            if (rsp_partial_quotient !== c.quot)
               report_mismatch($sformatf("quotient %h, want %h", rsp_partial_quotient, c.quot));
            if (rsp_conv_num !== c.cnum)
               report_mismatch($sformatf("conv_num %h, want %h", rsp_conv_num, c.cnum));
            if (rsp_conv_den !== c.cden)
               report_mismatch($sformatf("conv_den %h, want %h", rsp_conv_den, c.cden));
            if (rsp_term_index !== c.idx)
               report_mismatch($sformatf("term_index %0d, want %0d", rsp_term_index, c.idx));
            if (rsp_last_term !== c.last)
               report_mismatch($sformatf("last_term %b, want %b", rsp_last_term, c.last));
         end
      end
   end

   // Stimulus: directed fractions, then random ones, then drain.
   initial begin
      int                    burst_left;
      int                    pick;
      logic [ValueWidth-1:0] num;
      logic [DenWidth-1:0]   den;
      error_count    = 0;
      fractions_sent = 0;
      terms_checked  = 0;
      deep_fractions = 0;
      burst_left     = 0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_frac_num   = '0;
      req_frac_den   = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed fractions: extremes, zero numerator and denominator, long expansions.
      add_row(32'd0, 31'd1, 1, 32'd0);
      add_row(32'd5, 31'd1, 1, 32'd5);
      add_row(-32'sd5, 31'd1, 1, -32'sd5);
      add_row(32'h7fff_ffff, 31'd1, 1, 32'h7fff_ffff);
      add_row(32'h8000_0001, 31'd1, 1, 32'h8000_0001);
      add_row(32'h8000_0000, 31'd1, 1, 32'h8000_0000);
      add_row(32'd0, 31'h7fff_ffff, 1, 32'd0);
      add_row(32'd17, 31'd0);
      add_row(32'h8000_0000, 31'd0);
      add_row(32'd1, 31'h7fff_ffff);
      add_row(-32'sd1, 31'h7fff_ffff);
      add_row(32'h7fff_ffff, 31'h7fff_fffe);
      add_row(32'h8000_0001, 31'h7fff_ffff);
      add_row(32'h8000_0000, 31'd3);
      add_row(32'h8000_0000, 31'h7fff_ffff);
      add_row(32'd1836311903, 31'd1134903170);
      add_row(-32'sd1836311903, 31'd1134903170);
      add_row(32'd1134903170, 31'd1836311903);
      add_row(32'd355, 31'd113);
      add_row(-32'sd7, 31'd3);
      add_row(32'd6, 31'd4);
      add_row(32'hffff_ffff, 31'd2);
      foreach (directed_rows[i]) begin
         send_fraction(directed_rows[i].num, directed_rows[i].den,
                       directed_rows[i].typed, directed_rows[i].quot);
         sender_gap(burst_left);
      end

      // Random fractions: mostly full width, some small, a few edge values.
      repeat (NumRandom) begin
         pick = $urandom_range(0, 19);
         num  = $urandom;
         den  = DenWidth'($urandom);
         if (pick < 4) begin
            num = ValueWidth'($signed($urandom_range(0, 400)) - 200);
            den = DenWidth'($urandom_range(1, 60));
         end else if (pick == 4) begin
            den = '0;
         end else if (pick == 5) begin
            num = 32'h8000_0000;
         end else if (pick == 6) begin
            den = DenWidth'($urandom_range(1, 3));
         end
         send_fraction(num, den, 0, '0);
         sender_gap(burst_left);
      end
      req_valid = 1'b0;

      while (convergents_due.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      $display("Expanded %0d fractions into %0d checked convergents (%0d with over 20 terms).",
               fractions_sent, terms_checked, deep_fractions);
      $display("Directed extremes, zero terms and random traffic with stalls on both sides.");
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Overall time limit.
   initial begin
      #50ms;
      $display("timeout with %0d convergents outstanding", convergents_due.size());
      $display("TB_ERROR");
      $finish;
   end

endmodule

### files.f
hdl/cfc_pkg.sv
hdl/cfc_front.sv
hdl/cfc_queue.sv
hdl/cfc_div.sv
hdl/cfc_back.sv
hdl/continued_fraction_convergents.sv
tb/testbench.sv
